// ----- design/line_editor_with_echo_macros.svh -----
// Assertion macros for the line editor block.
`ifndef LINE_EDITOR_WITH_ECHO_MACROS_SVH
`define LINE_EDITOR_WITH_ECHO_MACROS_SVH
`ifndef SYNTHESIS
`define LED_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define LED_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LED_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define LED_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- design/led_pkg.sv -----
// Types and constants shared by the line editor modules.
package led_pkg;
	localparam int BYTE_W = 8;
	localparam int LEN_W = 9;
	localparam int BUFFER_DEPTH_DEF = 256;
	localparam logic [LEN_W-1:0] MAX_LEN_RESET = 9'd256;

	localparam logic [BYTE_W-1:0] CH_BS = 8'd8;
	localparam logic [BYTE_W-1:0] CH_LF = 8'd10;
	localparam logic [BYTE_W-1:0] CH_CR = 8'd13;
	localparam logic [BYTE_W-1:0] CH_SP = 8'd32;
	localparam logic [BYTE_W-1:0] CH_DEL = 8'd127;

	typedef enum logic [2:0] {
		KIND_BS  = 3'b001,
		KIND_NL  = 3'b010,
		KIND_CHR = 3'b100
	} kind_t;

	// one decoded request, as handed to the result sequencer
	typedef struct packed {
		logic              emit;
		kind_t             kind;
		logic [BYTE_W-1:0] data;
		logic [BYTE_W-1:0] pos;
		logic              done;
		logic [BYTE_W-1:0] len;
	} burst_t;
endpackage

// ----- design/led_dec.sv -----
// Request decode: classifies a received byte and computes the next write position.
module led_dec import led_pkg::*; #(
	parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic [BYTE_W-1:0] pos,
	input  logic [LEN_W-1:0]  max_len,
	output burst_t            burst,
	output logic [BYTE_W-1:0] next_pos
);
	localparam int CAP_I = (BUFFER_DEPTH < 256) ? BUFFER_DEPTH : 256;
	localparam logic [LEN_W-1:0] CAP = LEN_W'(CAP_I);
	localparam logic [LEN_W-1:0] MIN_SIZE = 9'd2;

	logic [LEN_W-1:0] eff;
	logic [LEN_W-1:0] limit;
	logic [LEN_W-1:0] nxt;
	logic             full;

	always_comb begin
		if (max_len < MIN_SIZE) begin
			eff = MIN_SIZE;
		end else if (max_len > CAP) begin
			eff = CAP;
		end else begin
			eff = max_len;
		end
	end

	assign limit = eff - 9'd1;
	assign nxt = {1'b0, pos} + 9'd1;
	assign full = (nxt >= limit);

	always_comb begin
		burst = '0;
		burst.kind = KIND_CHR;
		next_pos = pos;
		if (rx_byte inside {CH_BS, CH_DEL}) begin
			burst.kind = KIND_BS;
			burst.emit = (pos != '0);
			if (pos != '0) begin
				next_pos = pos - 8'd1;
			end
		end else if (rx_byte inside {CH_LF, CH_CR}) begin
			burst.kind = KIND_NL;
			burst.emit = 1'b1;
			burst.done = 1'b1;
			burst.len = pos;
			next_pos = '0;
		end else begin
			burst.emit = 1'b1;
			burst.data = rx_byte;
			burst.pos = pos;
			burst.done = full;
			burst.len = full ? nxt[BYTE_W-1:0] : '0;
			next_pos = full ? '0 : nxt[BYTE_W-1:0];
		end
	end
endmodule

// ----- design/led_emit.sv -----
// Result sequencer: holds one decoded request and plays out its echo results.
`include "line_editor_with_echo_macros.svh"
module led_emit import led_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  burst_t            req,
	output logic              req_take,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BYTE_W-1:0] tx_byte,
	output logic              store_write,
	output logic [BYTE_W-1:0] store_index,
	output logic [BYTE_W-1:0] store_byte,
	output logic              line_done,
	output logic [BYTE_W-1:0] line_length,
	output logic              last
);
	logic       busy_q;
	burst_t     burst_q;
	logic [1:0] step_q;
	logic       fire;
	logic       last_fire;

	always_comb begin
		tx_byte = burst_q.data;
		store_write = 1'b0;
		store_index = '0;
		store_byte = '0;
		line_done = 1'b0;
		line_length = '0;
		last = 1'b0;
		case (burst_q.kind)
			KIND_BS: begin
				tx_byte = (step_q == 2'd1) ? CH_SP : CH_BS;
				last = (step_q == 2'd2);
			end
			KIND_NL: begin
				tx_byte = (step_q == 2'd0) ? CH_LF : CH_CR;
				line_done = (step_q == 2'd1);
				line_length = (step_q == 2'd1) ? burst_q.len : '0;
				last = (step_q == 2'd1);
			end
			KIND_CHR: begin
				store_write = 1'b1;
				store_index = burst_q.pos;
				store_byte = burst_q.data;
				line_done = burst_q.done;
				line_length = burst_q.len;
				last = 1'b1;
			end
			default: begin
				last = 1'b1;
			end
		endcase
	end

	assign out_valid = busy_q;
	assign fire = busy_q && out_ready;
	assign last_fire = fire && last;
	// take the next request when idle or while the final result of this one leaves
	assign req_take = !busy_q || last_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (req_take) begin
			busy_q <= req_valid && req.emit;
			step_q <= '0;
		end else if (fire) begin
			step_q <= step_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take && req_valid && req.emit) begin
			burst_q <= req;
		end
	end

	`LED_ASSERT_IMP(a_chr_single, clk, arst_n, busy_q && burst_q.kind == KIND_CHR, step_q == 2'd0, "character request past its only result")
	`LED_ASSERT_IMP(a_nl_two, clk, arst_n, busy_q && burst_q.kind == KIND_NL, step_q != 2'd2 && step_q != 2'd3, "newline request past its second result")
	`LED_ASSERT_NEXT(a_hold_busy, clk, arst_n, fire && !last, busy_q, "request dropped before its final result")
	`LED_ASSERT_NEXT(a_load, clk, arst_n, req_take && req_valid && req.emit, busy_q && step_q == 2'd0, "request not loaded")
endmodule

// ----- design/line_editor_with_echo.sv -----
// Line editor with echo: a byte accepted here is seen by the sequencer in the cycle after its accept.
// The first result is valid once the sequencer takes the byte's request; while out_ready is high,
// one result leaves per cycle. A byte gives one to three results, set by the result sequencer;
// a backspace at line start gives no result.
// Reset clears the write position and sets the line size register to 256.
module line_editor_with_echo import led_pkg::*; #(
	parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write_en,
	input  logic [LEN_W-1:0]  cfg_write_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] rx_byte,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BYTE_W-1:0] tx_byte,
	output logic              store_write,
	output logic [BYTE_W-1:0] store_index,
	output logic [BYTE_W-1:0] store_byte,
	output logic              line_done,
	output logic [BYTE_W-1:0] line_length,
	output logic              last
);
	logic              valid_s1;
	logic [BYTE_W-1:0] rx_s1;
	logic [BYTE_W-1:0] pos_q;
	logic [LEN_W-1:0]  max_len_q;
	burst_t            req;
	logic [BYTE_W-1:0] next_pos;
	logic              req_take;
	logic              s1_take;

	assign s1_take = valid_s1 && req_take;
	assign in_ready = !valid_s1 || req_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rx_s1 <= rx_byte;
		end
	end

	// a size write abandons the line in progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_write_en) begin
			pos_q <= '0;
			max_len_q <= cfg_write_data;
		end else if (s1_take) begin
			pos_q <= next_pos;
		end
	end

	led_dec #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_dec (
		.rx_byte  (rx_s1),
		.pos      (pos_q),
		.max_len  (max_len_q),
		.burst    (req),
		.next_pos (next_pos)
	);

	led_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (valid_s1),
		.req         (req),
		.req_take    (req_take),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.tx_byte     (tx_byte),
		.store_write (store_write),
		.store_index (store_index),
		.store_byte  (store_byte),
		.line_done   (line_done),
		.line_length (line_length),
		.last        (last)
	);
endmodule

// ----- tb/sv/tb_line_editor_with_echo.sv -----
// Self-checking testbench for the line editor: echo, buffer writes and line completion.
`timescale 1ns / 1ps

module tb_line_editor_with_echo;
	import led_pkg::*;

	localparam int LINE_DEPTH = BUFFER_DEPTH_DEF;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [BYTE_W-1:0] tx;
		logic              wr;
		logic [BYTE_W-1:0] idx;
		logic [BYTE_W-1:0] chr;
		logic              done;
		logic [BYTE_W-1:0] len;
		logic              last;
	} echo_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_write_en = 1'b0;
	logic [LEN_W-1:0]  cfg_write_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [BYTE_W-1:0] rx_byte = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [BYTE_W-1:0] tx_byte;
	logic              store_write;
	logic [BYTE_W-1:0] store_index;
	logic [BYTE_W-1:0] store_byte;
	logic              line_done;
	logic [BYTE_W-1:0] line_length;
	logic              last;

	// predictor state
	logic [LEN_W-1:0]  line_size_reg = MAX_LEN_RESET;
	logic [BYTE_W-1:0] line_pos = '0;
	echo_t             expected_echoes[$];
	echo_t             want;

	int in_idle_pct = 0;
	int out_idle_pct = 0;
	int fail_count = 0;
	int cycle_count = 0;

	line_editor_with_echo #(
		.BUFFER_DEPTH(LINE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.tx_byte(tx_byte),
		.store_write(store_write),
		.store_index(store_index),
		.store_byte(store_byte),
		.line_done(line_done),
		.line_length(line_length),
		.last(last)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_line_editor_with_echo: FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
	end

	function automatic int unsigned usable_size();
		int unsigned s;
		s = 32'(line_size_reg);
		if (s < 2) s = 2;
		if (s > LINE_DEPTH) s = LINE_DEPTH;
		if (s > 256) s = 256;
		return s;
	endfunction

	// Queue the echo results that one accepted request causes.
	task automatic predict_echo(input logic [BYTE_W-1:0] c, output bit ended);
		echo_t e;
		logic [BYTE_W:0] nxt;
		ended = 1'b0;
		e = '0;
		if (c == CH_BS || c == CH_DEL) begin
			if (line_pos != 8'd0) begin
				line_pos = line_pos - 8'd1;
				e.tx = CH_BS;
				expected_echoes.push_back(e);
				e.tx = CH_SP;
				expected_echoes.push_back(e);
				e.tx = CH_BS;
				e.last = 1'b1;
				expected_echoes.push_back(e);
			end
		end else if (c == CH_LF || c == CH_CR) begin
			e.tx = CH_LF;
			expected_echoes.push_back(e);
			e.tx = CH_CR;
			e.done = 1'b1;
			e.len = line_pos;
			e.last = 1'b1;
			expected_echoes.push_back(e);
			line_pos = '0;
			ended = 1'b1;
		end else begin
			nxt = {1'b0, line_pos} + 9'd1;
			e.tx = c;
			e.wr = 1'b1;
			e.idx = line_pos;
			e.chr = c;
			e.last = 1'b1;
			if (32'(nxt) >= usable_size() - 32'd1) begin
				e.done = 1'b1;
				e.len = nxt[BYTE_W-1:0];
				line_pos = '0;
				ended = 1'b1;
			end else begin
				line_pos = nxt[BYTE_W-1:0];
			end
			expected_echoes.push_back(e);
		end
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] c, output bit ended);
		while ($urandom_range(0, 99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= c;
		do @(posedge clk); while (!in_ready);
		predict_echo(c, ended);
	endtask

	task automatic send_bytes(input logic [BYTE_W-1:0] seq[$]);
		bit ended;
		foreach (seq[i]) send_byte(seq[i], ended);
	endtask

	// Hold off the sender until every result is out and the block is quiet.
	task automatic drain_echoes();
		in_valid <= 1'b0;
		while (expected_echoes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_line_size(input logic [LEN_W-1:0] size);
		drain_echoes();
		cfg_write_en <= 1'b1;
		cfg_write_data <= size;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		line_size_reg = size;
		line_pos = '0;
	endtask

	function automatic logic [BYTE_W-1:0] ordinary_char();
		logic [BYTE_W-1:0] c;
		do c = BYTE_W'($urandom_range(0, 255));
		while (c == CH_BS || c == CH_DEL || c == CH_LF || c == CH_CR);
		return c;
	endfunction

	// Mostly printable text with edits and line ends, some raw noise.
	function automatic logic [BYTE_W-1:0] line_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return BYTE_W'($urandom_range(32, 126));
		if (r < 77) return BYTE_W'($urandom_range(0, 255));
		if (r < 90) return ($urandom_range(0, 1) != 0) ? CH_BS : CH_DEL;
		return ($urandom_range(0, 1) != 0) ? CH_LF : CH_CR;
	endfunction

	task automatic test_editing_at_default_size();
		send_bytes('{CH_BS, CH_DEL, 8'h41, 8'h00, 8'hFF, 8'h80, CH_DEL, CH_BS, CH_BS, CH_BS,
			CH_LF, 8'h68, 8'h69, CH_CR});
	endtask

	task automatic test_line_size_extremes();
		write_line_size(9'd0);
		send_bytes('{8'h71, 8'h7E, CH_BS, CH_CR});
		write_line_size(9'd1);
		send_bytes('{8'h7A});
		write_line_size(9'd2);
		send_bytes('{8'hAA});
		write_line_size(9'd3);
		send_bytes('{8'h61, 8'h62});
		write_line_size(9'd511);
		send_bytes('{8'h78});
		// abandon the partial line
		write_line_size(9'd256);
		send_bytes('{CH_BS, CH_LF});
	endtask

	task automatic test_random_short_lines(input int per_size);
		bit ended;
		logic [LEN_W-1:0] size;
		for (int g = 0; g < 3; g++) begin
			if ($urandom_range(0, 4) == 0) size = LEN_W'($urandom_range(0, 511));
			else size = LEN_W'($urandom_range(2, 12));
			write_line_size(size);
			for (int i = 0; i < per_size; i++) begin
				if (g == 1 && i == per_size / 2) drain_echoes();
				send_byte(line_char(), ended);
			end
		end
	endtask

	task automatic test_full_line();
		bit ended;
		int count;
		write_line_size(9'd256);
		ended = 1'b0;
		count = 0;
		while (!ended && count < 600) begin
			if ($urandom_range(0, 99) < 2) send_byte(CH_DEL, ended);
			else send_byte(ordinary_char(), ended);
			count++;
		end
	endtask

	function automatic void check_field(input string name, input logic [BYTE_W-1:0] exp_val,
			input logic [BYTE_W-1:0] got_val);
		if (got_val !== exp_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, got_val);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_echoes.size() == 0) begin
				$error("unexpected result: tx_byte %0d", tx_byte);
				fail_count++;
			end else begin
				want = expected_echoes.pop_front();
				check_field("tx_byte", want.tx, tx_byte);
				check_field("store_write", want.wr, store_write);
				check_field("store_index", want.idx, store_index);
				check_field("store_byte", want.chr, store_byte);
				check_field("line_done", want.done, line_done);
				check_field("line_length", want.len, line_length);
				check_field("last", want.last, last);
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		in_idle_pct = 21;
		out_idle_pct = 64;
		test_editing_at_default_size();
		test_line_size_extremes();
		test_random_short_lines(4);

		in_idle_pct = 64;
		out_idle_pct = 21;
		test_random_short_lines(4);

		in_idle_pct = 0;
		out_idle_pct = 0;
		test_full_line();

		drain_echoes();
		if (fail_count == 0) begin
			$display("tb_line_editor_with_echo: PASS");
		end else begin
			$display("tb_line_editor_with_echo: FAIL");
		end
		$finish;
	end

endmodule

// ----- line_editor_with_echo.f -----
+incdir+design
design/led_pkg.sv
design/led_dec.sv
design/led_emit.sv
design/line_editor_with_echo.sv
tb/sv/tb_line_editor_with_echo.sv
